// File: rtl/core/hkbw_pkg.sv
// hkbw_pkg: shared types, constants and the key lookup table of the
// hid_key_to_bios_word_ring block. No dependencies.

package hkbw_pkg;

  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned FILL_W     = 5;

  localparam logic [7:0] USAGE_RETURN = 8'h28;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CTRL_OFFSET  = 8'h60;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_IGNORED    = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_READ_OK    = 3'd3,
    ST_READ_EMPTY = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] scan;
    logic [7:0] plain;
    logic [7:0] shifted;
  } key_entry_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } hkbw_cmd_t;

  typedef struct packed {
    logic out_free;
  } hkbw_sts_t;

  // usage code to set-1 make code and ascii; scan of zero means unmapped
  function automatic key_entry_t key_lookup(input logic [7:0] usage);
    key_entry_t e;
    e = '0;
    unique case (usage)
      8'h04: e = '{8'h1E, 8'h61, 8'h41};
      8'h05: e = '{8'h30, 8'h62, 8'h42};
      8'h06: e = '{8'h2E, 8'h63, 8'h43};
      8'h07: e = '{8'h20, 8'h64, 8'h44};
      8'h08: e = '{8'h12, 8'h65, 8'h45};
      8'h09: e = '{8'h21, 8'h66, 8'h46};
      8'h0A: e = '{8'h22, 8'h67, 8'h47};
      8'h0B: e = '{8'h23, 8'h68, 8'h48};
      8'h0C: e = '{8'h17, 8'h69, 8'h49};
      8'h0D: e = '{8'h24, 8'h6A, 8'h4A};
      8'h0E: e = '{8'h25, 8'h6B, 8'h4B};
      8'h0F: e = '{8'h26, 8'h6C, 8'h4C};
      8'h10: e = '{8'h32, 8'h6D, 8'h4D};
      8'h11: e = '{8'h31, 8'h6E, 8'h4E};
      8'h12: e = '{8'h18, 8'h6F, 8'h4F};
      8'h13: e = '{8'h19, 8'h70, 8'h50};
      8'h14: e = '{8'h10, 8'h71, 8'h51};
      8'h15: e = '{8'h13, 8'h72, 8'h52};
      8'h16: e = '{8'h1F, 8'h73, 8'h53};
      8'h17: e = '{8'h14, 8'h74, 8'h54};
      8'h18: e = '{8'h16, 8'h75, 8'h55};
      8'h19: e = '{8'h2F, 8'h76, 8'h56};
      8'h1A: e = '{8'h11, 8'h77, 8'h57};
      8'h1B: e = '{8'h2D, 8'h78, 8'h58};
      8'h1C: e = '{8'h15, 8'h79, 8'h59};
      8'h1D: e = '{8'h2C, 8'h7A, 8'h5A};
      8'h1E: e = '{8'h02, 8'h31, 8'h21};
      8'h1F: e = '{8'h03, 8'h32, 8'h40};
      8'h20: e = '{8'h04, 8'h33, 8'h23};
      8'h21: e = '{8'h05, 8'h34, 8'h24};
      8'h22: e = '{8'h06, 8'h35, 8'h25};
      8'h23: e = '{8'h07, 8'h36, 8'h5E};
      8'h24: e = '{8'h08, 8'h37, 8'h26};
      8'h25: e = '{8'h09, 8'h38, 8'h2A};
      8'h26: e = '{8'h0A, 8'h39, 8'h28};
      8'h27: e = '{8'h0B, 8'h30, 8'h29};
      8'h28: e = '{8'h1C, 8'h0D, 8'h0D};
      8'h29: e = '{8'h01, 8'h1B, 8'h1B};
      8'h2A: e = '{8'h0E, 8'h08, 8'h08};
      8'h2B: e = '{8'h0F, 8'h09, 8'h09};
      8'h2C: e = '{8'h39, 8'h20, 8'h20};
      8'h2D: e = '{8'h0C, 8'h2D, 8'h5F};
      8'h2E: e = '{8'h0D, 8'h3D, 8'h2B};
      8'h2F: e = '{8'h1A, 8'h5B, 8'h7B};
      8'h30: e = '{8'h1B, 8'h5D, 8'h7D};
      8'h31: e = '{8'h2B, 8'h5C, 8'h7C};
      8'h33: e = '{8'h27, 8'h3B, 8'h3A};
      8'h34: e = '{8'h28, 8'h27, 8'h22};
      8'h35: e = '{8'h29, 8'h60, 8'h7E};
      8'h36: e = '{8'h33, 8'h2C, 8'h3C};
      8'h37: e = '{8'h34, 8'h2E, 8'h3E};
      8'h38: e = '{8'h35, 8'h2F, 8'h3F};
      8'h3A: e = '{8'h3B, 8'h00, 8'h00};
      8'h3B: e = '{8'h3C, 8'h00, 8'h00};
      8'h3C: e = '{8'h3D, 8'h00, 8'h00};
      8'h3D: e = '{8'h3E, 8'h00, 8'h00};
      8'h3E: e = '{8'h3F, 8'h00, 8'h00};
      8'h3F: e = '{8'h40, 8'h00, 8'h00};
      8'h40: e = '{8'h41, 8'h00, 8'h00};
      8'h41: e = '{8'h42, 8'h00, 8'h00};
      8'h42: e = '{8'h43, 8'h00, 8'h00};
      8'h43: e = '{8'h44, 8'h00, 8'h00};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/core/hkbw_ram.sv
// hkbw_ram: generic single write port, single read port ram with registered
// read data. No dependencies.

module hkbw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/hkbw_ctrl.sv
// hkbw_ctrl: sequencing state machine of the key word ring.
// Depends on hkbw_pkg.

module hkbw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output hkbw_pkg::hkbw_cmd_t cmd_o,
  input  hkbw_pkg::hkbw_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && ready_q) begin
            state_q <= S_EXEC;
            ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o    = ready_q;
  assign cmd_o.capture = in_valid_i && ready_q;
  assign cmd_o.execute = (state_q == S_EXEC);
  assign cmd_o.load    = (state_q == S_LOAD) && sts_i.out_free;

  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> state_q == S_IDLE)
    else $error("ready outside idle");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.out_free)
    else $error("load into occupied output register");

  a_exec_then_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> state_q == S_LOAD)
    else $error("execute not followed by load");

endmodule

// File: rtl/core/hkbw_dp.sv
// hkbw_dp: key translation, ring indices, word ram and output register.
// Depends on hkbw_pkg and hkbw_ram.

module hkbw_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hkbw_pkg::hkbw_cmd_t cmd_i,
  output hkbw_pkg::hkbw_sts_t sts_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          usage_i,
  input  logic                shift_held_i,
  input  logic                ctrl_held_i,
  input  logic                alt_held_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         key_word_o,
  output logic [2:0]          status_o,
  output logic [4:0]          fill_count_o
);

  localparam int unsigned PW = hkbw_pkg::PTR_W;
  localparam logic [PW-1:0] LAST_IDX = PW'(hkbw_pkg::RING_DEPTH - 1);

  hkbw_pkg::op_e     op_q;
  logic [7:0]        usage_q;
  logic              shift_q, ctrl_q, alt_q;
  logic [PW-1:0]     rd_q, rd_d, wr_q, wr_d, rd_next, wr_next, fill_d, fill_q;
  logic [PW:0]       diff;
  hkbw_pkg::status_e status_d, status_q;
  logic              read_ok_d, read_ok_q;
  logic              ram_we;
  logic [15:0]       ram_rdata, word_d;
  hkbw_pkg::key_entry_t entry;
  logic              mapped;
  logic [7:0]        low_byte;
  logic              out_valid_q;
  logic [15:0]       out_word_q;
  hkbw_pkg::status_e out_status_q;
  logic [PW-1:0]     out_fill_q;

  // translation of the captured key
  always_comb begin
    entry  = hkbw_pkg::key_lookup(usage_q);
    mapped = (entry.scan != 8'h00) && !((usage_q == hkbw_pkg::USAGE_RETURN) && alt_q);
    if (alt_q) begin
      low_byte = 8'h00;
    end else if (ctrl_q && (entry.plain >= hkbw_pkg::CHAR_LOWER_A)
                 && (entry.plain <= hkbw_pkg::CHAR_LOWER_Z)) begin
      low_byte = entry.plain - hkbw_pkg::CTRL_OFFSET;
    end else begin
      low_byte = shift_q ? entry.shifted : entry.plain;
    end
    word_d = {entry.scan, low_byte};
  end

  assign rd_next = (rd_q == LAST_IDX) ? '0 : rd_q + PW'(1);
  assign wr_next = (wr_q == LAST_IDX) ? '0 : wr_q + PW'(1);

  always_comb begin
    rd_d      = rd_q;
    wr_d      = wr_q;
    status_d  = hkbw_pkg::ST_IGNORED;
    read_ok_d = 1'b0;
    ram_we    = 1'b0;
    unique case (op_q)
      hkbw_pkg::OP_KEY: begin
        if (!mapped) begin
          status_d = hkbw_pkg::ST_IGNORED;
        end else if (wr_next == rd_q) begin
          status_d = hkbw_pkg::ST_DROPPED;
        end else begin
          status_d = hkbw_pkg::ST_QUEUED;
          ram_we   = cmd_i.execute;
          wr_d     = wr_next;
        end
      end
      hkbw_pkg::OP_READ: begin
        if (rd_q == wr_q) begin
          status_d = hkbw_pkg::ST_READ_EMPTY;
        end else begin
          status_d  = hkbw_pkg::ST_READ_OK;
          read_ok_d = 1'b1;
          rd_d      = rd_next;
        end
      end
      hkbw_pkg::OP_CLEAR: begin
        status_d = hkbw_pkg::ST_QUEUED;
        rd_d     = '0;
        wr_d     = '0;
      end
      hkbw_pkg::OP_NOP: begin
        status_d = hkbw_pkg::ST_IGNORED;
      end
      default: begin
        status_d = hkbw_pkg::ST_IGNORED;
      end
    endcase
    if (wr_d >= rd_d) begin
      diff = {1'b0, wr_d} - {1'b0, rd_d};
    end else begin
      diff = {1'b0, wr_d} + (PW+1)'(hkbw_pkg::RING_DEPTH) - {1'b0, rd_d};
    end
    fill_d = PW'(diff);
  end

  hkbw_ram #(
    .WIDTH(hkbw_pkg::WORD_W),
    .DEPTH(hkbw_pkg::RING_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_q),
    .wdata_i(word_d),
    .re_i   (cmd_i.execute),
    .raddr_i(rd_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= hkbw_pkg::op_e'(op_i);
      usage_q <= usage_i;
      shift_q <= shift_held_i;
      ctrl_q  <= ctrl_held_i;
      alt_q   <= alt_held_i;
    end
    if (cmd_i.execute) begin
      status_q  <= status_d;
      fill_q    <= fill_d;
      read_ok_q <= read_ok_d;
    end
    if (cmd_i.load) begin
      out_word_q   <= read_ok_q ? ram_rdata : '0;
      out_status_q <= status_q;
      out_fill_q   <= fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q        <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.execute) begin
        rd_q <= rd_d;
        wr_q <= wr_d;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign key_word_o     = out_word_q;
  assign status_o       = out_status_q;
  assign fill_count_o   = 5'(out_fill_q);

  a_rd_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= LAST_IDX)
    else $error("read index out of range");

  a_wr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= LAST_IDX)
    else $error("write index out of range");

  a_word_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != hkbw_pkg::ST_READ_OK) |-> out_word_q == '0)
    else $error("key word set outside a successful read");

endmodule

// File: rtl/core/hid_key_to_bios_word_ring.sv
// hid_key_to_bios_word_ring: usb hid key events to pc bios key words in a ring.
// Each event passes through the capture, execute (with ram access) and load steps in order;
// a new event is taken only after the last result is loaded, and load waits for a free output register.
// The ram read data is registered, which sets the load step after execute.
// Reset: asynchronous, active low; clears ring indices and output valid.
// Depends on hkbw_pkg, hkbw_ctrl, hkbw_dp and hkbw_ram.

module hid_key_to_bios_word_ring (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // usage[7:0], shift_held[8], ctrl_held[9],
                                     // alt_held[10], zero[15:11]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // key_word[15:0], fill_count[20:16], zero[23:21]
  output logic [2:0]  m_axis_tuser   // status[2:0]
);

  hkbw_pkg::hkbw_cmd_t cmd;
  hkbw_pkg::hkbw_sts_t sts;
  logic [15:0]         key_word;
  logic [4:0]          fill_count;

  hkbw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  hkbw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tuser),
    .usage_i     (s_axis_tdata[7:0]),
    .shift_held_i(s_axis_tdata[8]),
    .ctrl_held_i (s_axis_tdata[9]),
    .alt_held_i  (s_axis_tdata[10]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .key_word_o  (key_word),
    .status_o    (m_axis_tuser),
    .fill_count_o(fill_count)
  );

  assign m_axis_tdata = {3'b000, fill_count, key_word};

endmodule

// File: verif/hkbw_bios_word_checker.sv
`timescale 1ns / 100ps
// hkbw_bios_word_checker: watches both stream channels of hid_key_to_bios_word_ring,
// predicts every result from its own key table and word ring and counts mismatches.
// Depends on hkbw_pkg.

module hkbw_bios_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // usage[7:0], shift_held[8], ctrl_held[9],
                                     // alt_held[10], zero[15:11]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // key_word[15:0], fill_count[20:16], zero[23:21]
  input  logic [2:0]  m_axis_tuser,  // status[2:0]
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [hkbw_pkg::WORD_W-1:0] key_word;
    hkbw_pkg::status_e           status;
    logic [hkbw_pkg::FILL_W-1:0] fill_count;
  } bios_result_t;

  // indexed by usage minus 4; zero make code marks an unmapped key
  logic [7:0] make_code [0:63] = '{
    8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
    8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
    8'h15, 8'h2C,
    8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
    8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B, 8'h00, 8'h27,
    8'h28, 8'h29, 8'h33, 8'h34, 8'h35, 8'h00,
    8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44
  };

  logic [7:0] plain_char [0:63] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C,
    8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
    8'h79, 8'h7A,
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h0D, 8'h1B, 8'h08, 8'h09, 8'h20, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h00, 8'h3B,
    8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic [7:0] shifted_char [0:63] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C,
    8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
    8'h59, 8'h5A,
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
    8'h0D, 8'h1B, 8'h08, 8'h09, 8'h20, 8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C, 8'h00, 8'h3A,
    8'h22, 8'h7E, 8'h3C, 8'h3E, 8'h3F, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic [hkbw_pkg::WORD_W-1:0] word_ring [hkbw_pkg::RING_DEPTH];
  int unsigned                 rd_slot;
  int unsigned                 wr_slot;
  bios_result_t                bios_result_q [$];

  function automatic logic [hkbw_pkg::WORD_W-1:0] bios_word_of(logic [7:0] usage,
                                                               logic shift, logic ctrl,
                                                               logic alt);
    logic [5:0] idx;
    logic [7:0] code;
    logic [7:0] ch;
    if (usage < 8'h04 || usage > 8'h43 || (usage == hkbw_pkg::USAGE_RETURN && alt)) begin
      return '0;
    end
    idx  = 6'(usage - 8'h04);
    code = make_code[idx];
    if (code == 8'h00) begin
      return '0;
    end
    if (alt) begin
      ch = 8'h00;
    end else if (ctrl && plain_char[idx] >= hkbw_pkg::CHAR_LOWER_A
                 && plain_char[idx] <= hkbw_pkg::CHAR_LOWER_Z) begin
      ch = plain_char[idx] - hkbw_pkg::CTRL_OFFSET;
    end else begin
      ch = shift ? shifted_char[idx] : plain_char[idx];
    end
    return {code, ch};
  endfunction

  function automatic bios_result_t apply_key_event(hkbw_pkg::op_e op, logic [7:0] usage,
                                                   logic shift, logic ctrl, logic alt);
    bios_result_t r;
    logic [hkbw_pkg::WORD_W-1:0] w;
    r = '{key_word: '0, status: hkbw_pkg::ST_IGNORED, fill_count: '0};
    case (op)
      hkbw_pkg::OP_KEY: begin
        w = bios_word_of(usage, shift, ctrl, alt);
        if (w == '0) begin
          r.status = hkbw_pkg::ST_IGNORED;
        end else if ((wr_slot + 1) % hkbw_pkg::RING_DEPTH == rd_slot) begin
          r.status = hkbw_pkg::ST_DROPPED;
        end else begin
          word_ring[wr_slot] = w;
          wr_slot  = (wr_slot + 1) % hkbw_pkg::RING_DEPTH;
          r.status = hkbw_pkg::ST_QUEUED;
        end
      end
      hkbw_pkg::OP_READ: begin
        if (rd_slot == wr_slot) begin
          r.status = hkbw_pkg::ST_READ_EMPTY;
        end else begin
          r.key_word = word_ring[rd_slot];
          rd_slot    = (rd_slot + 1) % hkbw_pkg::RING_DEPTH;
          r.status   = hkbw_pkg::ST_READ_OK;
        end
      end
      hkbw_pkg::OP_CLEAR: begin
        rd_slot  = 0;
        wr_slot  = 0;
        r.status = hkbw_pkg::ST_QUEUED;
      end
      default: r.status = hkbw_pkg::ST_IGNORED;
    endcase
    r.fill_count = hkbw_pkg::FILL_W'((wr_slot + hkbw_pkg::RING_DEPTH - rd_slot)
                                     % hkbw_pkg::RING_DEPTH);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bios_result_t want;
    if (!rst_ni) begin
      rd_slot = 0;
      wr_slot = 0;
      bios_result_q.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (bios_result_q.size() == 0) begin
          $error("result transfer with no result awaited: tdata %h tuser %h",
                 m_axis_tdata, m_axis_tuser);
          fail_count_o++;
        end else begin
          want = bios_result_q.pop_front();
          if (m_axis_tdata[15:0] !== want.key_word) begin
            $error("key_word: expected %h, actual %h", want.key_word, m_axis_tdata[15:0]);
            fail_count_o++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            fail_count_o++;
          end
          if (m_axis_tdata[20:16] !== want.fill_count) begin
            $error("fill_count: expected %0d, actual %0d", want.fill_count,
                   m_axis_tdata[20:16]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bios_result_q.push_back(apply_key_event(hkbw_pkg::op_e'(s_axis_tuser),
                                                s_axis_tdata[7:0], s_axis_tdata[8],
                                                s_axis_tdata[9], s_axis_tdata[10]));
      end
      pending_o = bios_result_q.size();
    end
  end

endmodule

// File: verif/hid_key_to_bios_word_ring_tb.sv
`timescale 1ns / 100ps
// hid_key_to_bios_word_ring_tb: drives key, read, clear and no-op events into the block
// with random idling on both sides and gives the verdict. Depends on hkbw_pkg,
// hkbw_bios_word_checker and the block itself.

module hid_key_to_bios_word_ring_tb;

  localparam int RANDOM_EVENTS = 1350;
  localparam int QUIET_FROM    = 1150;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 300000;

  typedef enum logic [1:0] {
    MIX_TYPING,
    MIX_DRAIN,
    MIX_NOISE
  } mix_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int   fail_count;
  int   pending;
  int   cycles;
  logic idle_on;
  logic hold_off_req;

  hid_key_to_bios_word_ring dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  hkbw_bios_word_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_event(hkbw_pkg::op_e op, logic [7:0] usage, logic shift, logic ctrl,
                            logic alt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, alt, ctrl, shift, usage};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random_event(mix_e mix);
    int unsigned   pick;
    hkbw_pkg::op_e op;
    logic [7:0]    usage;
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_TYPING: op = pick < 85 ? hkbw_pkg::OP_KEY : pick < 96 ? hkbw_pkg::OP_READ :
                       pick < 98 ? hkbw_pkg::OP_NOP : hkbw_pkg::OP_CLEAR;
      MIX_DRAIN:  op = pick < 70 ? hkbw_pkg::OP_READ : pick < 97 ? hkbw_pkg::OP_KEY :
                       pick < 99 ? hkbw_pkg::OP_NOP : hkbw_pkg::OP_CLEAR;
      default:    op = hkbw_pkg::op_e'($urandom_range(0, 3));
    endcase
    if (mix != MIX_NOISE && $urandom_range(0, 9) != 0) begin
      usage = 8'($urandom_range(8'h04, 8'h43));
    end else begin
      usage = 8'($urandom_range(0, 255));
    end
    send_event(op, usage, $urandom_range(0, 9) < 3, $urandom_range(0, 9) < 2,
               $urandom_range(0, 9) < 1);
  endtask

  // receiver: random back-pressure bursts, plus one long hold-off on request
  initial begin
    logic held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        held = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int   sent;
    int   run_len;
    mix_e mix;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = hkbw_pkg::OP_NOP;
    idle_on       = 1'b1;
    hold_off_req  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // letters with each modifier, ctrl on a non-letter, alt on return
    send_event(hkbw_pkg::OP_KEY, 8'h04, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h04, 1'b1, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h04, 1'b0, 1'b1, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h04, 1'b0, 1'b0, 1'b1);
    send_event(hkbw_pkg::OP_KEY, 8'h1D, 1'b1, 1'b1, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h1E, 1'b0, 1'b1, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h27, 1'b1, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, hkbw_pkg::USAGE_RETURN, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, hkbw_pkg::USAGE_RETURN, 1'b0, 1'b0, 1'b1);
    send_event(hkbw_pkg::OP_KEY, hkbw_pkg::USAGE_RETURN, 1'b1, 1'b1, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h2B, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h38, 1'b1, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h43, 1'b1, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h3A, 1'b0, 1'b0, 1'b1);
    send_event(hkbw_pkg::OP_KEY, 8'h32, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h39, 1'b1, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_event(hkbw_pkg::OP_KEY, 8'h03, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_KEY, 8'h44, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_NOP, 8'h04, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
    send_event(hkbw_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 1'b0);

    // runs of typing fill the ring to overflow, runs of reads drain it past empty
    sent = 0;
    while (sent < RANDOM_EVENTS) begin
      mix     = mix_e'($urandom_range(0, 2));
      run_len = $urandom_range(10, 60);
      repeat (run_len) begin
        if (sent == HOLD_AT) hold_off_req = 1'b1;
        if (sent == QUIET_FROM) idle_on = 1'b0;
        send_random_event(mix);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
